[rtl/assert_macros.svh]
// assertion macros shared by the loader modules
// each one checks on the rising edge of clk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset only
`define HLML_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define HLML_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/hlml_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlml_pkg
// Shared types and codes of the hex text loader: result kinds, error codes,
// and the job word passed from the parser to the result sequencer.
// ----------------------------------------------------------------------------
package hlml_pkg;

    // result kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // error codes
    localparam logic [1:0] ERR_INVALID = 2'd0;
    localparam logic [1:0] ERR_DIGITS  = 2'd1;
    localparam logic [1:0] ERR_ADDR    = 2'd2;

    // what follows the byte writes of a job
    localparam logic [1:0] TAIL_NONE  = 2'd0;
    localparam logic [1:0] TAIL_DONE  = 2'd1;
    localparam logic [1:0] TAIL_ERROR = 2'd2;

    // one job: all results caused by one input character
    typedef struct packed {
        logic [31:0] value;     // bytes to write, low byte first
        logic [15:0] addr;      // address of the first byte
        logic [2:0]  nwrites;   // byte writes, 0 to 4
        logic [1:0]  tail;      // closing result
        logic [1:0]  err;       // error code of an error tail
        logic [16:0] count;     // byte count of a done tail
    } job_t;

    // queue status seen by the input handshake and the sequencer
    typedef struct packed {
        logic full;
        logic valid;
    } q_stat_t;

endpackage

[rtl/hlml_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlml_front
// Character parser: classifies each accepted character, keeps the pending
// value, digit count and write address, and issues one job per character
// that causes results.
// ----------------------------------------------------------------------------
module hlml_front
    import hlml_pkg::*;
#(
    parameter int ADDR_BITS  = 16,
    parameter int MAX_DIGITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  char_code,
    input  logic        cfg_wr_en,
    input  logic [16:0] cfg_wr_data,
    output logic        push,
    output job_t        job
);

    // at least three bits so the byte cap of four fits
    localparam int DC_W = (MAX_DIGITS < 4) ? 3 : $clog2(MAX_DIGITS + 1);
    localparam logic [16:0] ADDR_CAP =
        (ADDR_BITS >= 17) ? 17'h1FFFF : 17'(64'd1 << ADDR_BITS);

    logic [16:0]     mem_span_reg;
    logic [31:0]     acc_reg, acc_next;
    logic [DC_W-1:0] dc_reg, dc_next;
    logic [16:0]     addr_reg, addr_next;

    logic            is_hex;
    logic [3:0]      digit;
    logic [16:0]     limit;
    logic [16:0]     room;
    logic [DC_W-1:0] half;
    logic [2:0]      nbytes;
    logic            short_room;
    logic [2:0]      nwr;
    logic [16:0]     flush_end;

    always_comb
    begin
        is_hex = 1'b1;
        digit  = '0;
        if (char_code >= 8'h30 && char_code <= 8'h39)
        begin
            digit = 4'(char_code - 8'h30);
        end
        else if (char_code >= 8'h61 && char_code <= 8'h66)
        begin
            digit = 4'(char_code - 8'h57);
        end
        else if (char_code >= 8'h41 && char_code <= 8'h46)
        begin
            digit = 4'(char_code - 8'h37);
        end
        else
        begin
            is_hex = 1'b0;
        end
    end

    // bytes due for the pending value, and room left below the limit
    always_comb
    begin
        limit      = (mem_span_reg < ADDR_CAP) ? mem_span_reg : ADDR_CAP;
        room       = (addr_reg < limit) ? (limit - addr_reg) : '0;
        half       = (dc_reg >> 1) + DC_W'(dc_reg[0]);
        nbytes     = (half > DC_W'(4)) ? 3'd4 : 3'(half);
        short_room = room < {14'd0, nbytes};
        nwr        = short_room ? room[2:0] : nbytes;
        flush_end  = addr_reg + {14'd0, nwr};
    end

    always_comb
    begin
        acc_next    = acc_reg;
        dc_next     = dc_reg;
        addr_next   = addr_reg;
        push        = 1'b0;
        job.value   = acc_reg;
        job.addr    = addr_reg[15:0];
        job.nwrites = '0;
        job.tail    = TAIL_NONE;
        job.err     = ERR_INVALID;
        job.count   = '0;
        if (accept)
        begin
            if (char_code == 8'h00)
            begin
                // end of stream: flush, then done unless the flush overran
                push      = 1'b1;
                acc_next  = '0;
                dc_next   = '0;
                addr_next = '0;
                if (dc_reg != '0)
                begin
                    job.nwrites = nwr;
                    job.count   = flush_end;
                    if (short_room)
                    begin
                        job.tail = TAIL_ERROR;
                        job.err  = ERR_ADDR;
                    end
                    else
                    begin
                        job.tail = TAIL_DONE;
                    end
                end
                else
                begin
                    job.tail  = TAIL_DONE;
                    job.count = addr_reg;
                end
            end
            else if (is_hex)
            begin
                if (dc_reg >= DC_W'(MAX_DIGITS))
                begin
                    push      = 1'b1;
                    job.tail  = TAIL_ERROR;
                    job.err   = ERR_DIGITS;
                    acc_next  = '0;
                    dc_next   = '0;
                    addr_next = '0;
                end
                else
                begin
                    acc_next = {acc_reg[27:0], digit};
                    dc_next  = dc_reg + DC_W'(1);
                end
            end
            else if (char_code <= 8'h20)
            begin
                if (dc_reg != '0)
                begin
                    push        = 1'b1;
                    job.nwrites = nwr;
                    acc_next    = '0;
                    dc_next     = '0;
                    if (short_room)
                    begin
                        job.tail  = TAIL_ERROR;
                        job.err   = ERR_ADDR;
                        addr_next = '0;
                    end
                    else
                    begin
                        addr_next = flush_end;
                    end
                end
            end
            else
            begin
                push      = 1'b1;
                job.tail  = TAIL_ERROR;
                job.err   = ERR_INVALID;
                acc_next  = '0;
                dc_next   = '0;
                addr_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_span_reg <= 17'h10000;
            acc_reg      <= '0;
            dc_reg       <= '0;
            addr_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mem_span_reg <= cfg_wr_data;
            end
            acc_reg  <= acc_next;
            dc_reg   <= dc_next;
            addr_reg <= addr_next;
        end
    end

endmodule

[rtl/hlml_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlml_queue
// Small job queue between the parser and the result sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hlml_queue
    import hlml_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  job_t    push_job,
    input  logic    pop,
    output q_stat_t stat,
    output job_t    head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    `HLML_ASSERT(a_no_overflow, push |-> !stat.full || pop, "job pushed into a full queue")
    `HLML_ASSERT(a_no_underflow, pop |-> stat.valid, "job popped from an empty queue")
    `HLML_ASSERT_ALWAYS(a_count_range, count_reg <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule

[rtl/hlml_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlml_back
// Result sequencer: expands the job at the queue head into byte writes and
// a closing done or error result, one result a cycle into the output register while that register is free or taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hlml_back
    import hlml_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  q_stat_t     stat,
    input  job_t        head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [15:0] write_addr,
    output logic [7:0]  write_byte,
    output logic [16:0] byte_count,
    output logic [1:0]  error_code,
    output logic        last
);

    logic [2:0]  idx_reg, idx_next;
    logic        out_valid_reg;
    logic [1:0]  kind_reg, kind_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  byte_reg, byte_next;
    logic [16:0] count_reg, count_next;
    logic [1:0]  err_reg, err_next;
    logic        last_reg;

    logic [2:0]  total;
    logic        is_final;
    logic        load;

    always_comb
    begin
        total    = head.nwrites + ((head.tail != TAIL_NONE) ? 3'd1 : 3'd0);
        is_final = (idx_reg + 3'd1) == total;
        load     = stat.valid && (!out_valid_reg || out_ready);
        pop      = load && is_final;
        idx_next = pop ? 3'd0 : (load ? idx_reg + 3'd1 : idx_reg);
    end

    always_comb
    begin
        kind_next  = KIND_WRITE;
        addr_next  = '0;
        byte_next  = '0;
        count_next = '0;
        err_next   = '0;
        if (idx_reg < head.nwrites)
        begin
            addr_next = head.addr + {13'd0, idx_reg};
            case (idx_reg[1:0])
                2'd0:    byte_next = head.value[7:0];
                2'd1:    byte_next = head.value[15:8];
                2'd2:    byte_next = head.value[23:16];
                default: byte_next = head.value[31:24];
            endcase
        end
        else if (head.tail == TAIL_DONE)
        begin
            kind_next  = KIND_DONE;
            count_next = head.count;
        end
        else
        begin
            kind_next = KIND_ERROR;
            err_next  = head.err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg  <= kind_next;
            addr_reg  <= addr_next;
            byte_reg  <= byte_next;
            count_reg <= count_next;
            err_reg   <= err_next;
            last_reg  <= is_final;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign write_addr = addr_reg;
    assign write_byte = byte_reg;
    assign byte_count = count_reg;
    assign error_code = err_reg;
    assign last       = last_reg;

    `HLML_ASSERT(a_tail_is_last, out_valid_reg && kind_reg != KIND_WRITE |-> last_reg, "done or error not last")
    `HLML_ASSERT(a_job_held, load && !is_final |=> stat.valid, "job left the queue before its last result")
    `HLML_ASSERT(a_write_clean, out_valid_reg && kind_reg == KIND_WRITE |-> byte_count == '0 && error_code == '0, "stray fields on a byte write")

endmodule

[rtl/hex_text_le_memory_loader_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_text_le_memory_loader_unit
// Hex text loader: turns a stream of text characters into little-endian
// byte writes, closing with a done word carrying the byte count.
// ----------------------------------------------------------------------------
// The loader takes one character word per cycle while its job queue has
// room; characters that cause no result (hex digits, a separator with nothing
// pending) never occupy the queue. A character that ends a value produces up
// to five result words (up to four byte writes plus a done or error word),
// and the result sequencer delivers one result word per cycle while the
// output is taken, so a separator after an N-digit value yields ceil(N/2)
// byte writes, capped at four, plus any closing error word. The job queue
// of QUEUE_DEPTH entries lets the parser run ahead of the output by that
// many pending jobs. After reset the area size is 65536 bytes; the
// effective limit is the smaller of the area size and 2^ADDR_BITS. After
// any done or error word the loader starts again at address 0.
// ----------------------------------------------------------------------------
module hex_text_le_memory_loader_unit
    import hlml_pkg::*;
#(
    parameter int ADDR_BITS   = 16,
    parameter int MAX_DIGITS  = 8,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // character word in
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    // area size register
    input  logic        cfg_wr_en,
    input  logic [16:0] cfg_wr_data,
    // result word out
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [15:0] write_addr,
    output logic [7:0]  write_byte,
    output logic [16:0] byte_count,
    output logic [1:0]  error_code,
    output logic        last
);

    logic    accept;
    logic    push;
    logic    pop;
    job_t    push_job;
    job_t    head;
    q_stat_t stat;

    // a character is taken whenever a job slot is free
    assign in_ready = !stat.full;
    assign accept   = in_valid && in_ready;

    // parser: digit accumulation, address tracking, job issue
    hlml_front #(
        .ADDR_BITS  (ADDR_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .char_code   (char_code),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push        (push),
        .job         (push_job)
    );

    // decouples parsing from result delivery
    hlml_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .stat     (stat),
        .head     (head)
    );

    // expands each job into result words behind an output register
    hlml_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .stat       (stat),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .write_addr (write_addr),
        .write_byte (write_byte),
        .byte_count (byte_count),
        .error_code (error_code),
        .last       (last)
    );

endmodule
